// ===== rtl/core/esup_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package esup_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [2:0] CMD_SET_ENABLE = 3'd0;
  localparam logic [2:0] CMD_LINK       = 3'd1;
  localparam logic [2:0] CMD_TICK       = 3'd2;
  localparam logic [2:0] CMD_REPLY      = 3'd3;
  localparam logic [2:0] CMD_TIMEOUT    = 3'd4;

  localparam logic REG_LINK_WAIT      = 1'b0;
  localparam logic REG_RETRY_INTERVAL = 1'b1;

  localparam logic [15:0] RETRY_FALLBACK = 16'd1000;

  typedef struct packed {
    logic [15:0] link_wait;
    logic [15:0] retry_interval;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        enable_value;
    logic        link_connected;
    logic [31:0] gateway_address;
    logic [31:0] time_now;
    logic        start_ok;
  } item_t;

  typedef struct packed {
    logic        enabled;
    logic        link_up;
    logic [31:0] current_gateway;
    logic [31:0] link_up_time;
    logic        running;
    logic [31:0] running_gateway;
    logic [31:0] failure_time;
    logic [31:0] starts_total;
    logic [31:0] stops_total;
    logic [31:0] failures_total;
    logic [31:0] replies_total;
    logic [31:0] timeouts_total;
  } state_t;

  typedef struct packed {
    logic        stop_issued;
    logic        start_attempted;
    logic        start_failed;
    logic [31:0] target_gateway;
    logic        session_active;
    logic [31:0] started_count;
    logic [31:0] stopped_count;
    logic [31:0] failure_count;
    logic [31:0] reply_count;
    logic [31:0] timeout_count;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/esup_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esup_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [esup_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [esup_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [esup_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready,
  output esup_pkg::cfg_t                           cfg
);

  esup_pkg::cfg_t cfg_r;
  esup_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic           reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        esup_pkg::REG_LINK_WAIT:      cfg_nxt.link_wait      = pwdata[15:0];
        esup_pkg::REG_RETRY_INTERVAL: cfg_nxt.retry_interval = pwdata[15:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      esup_pkg::REG_LINK_WAIT:      prdata = {16'b0, cfg_r.link_wait};
      esup_pkg::REG_RETRY_INTERVAL: prdata = {16'b0, cfg_r.retry_interval};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.link_wait      <= '0;
      cfg_r.retry_interval <= esup_pkg::RETRY_FALLBACK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/esup_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

module esup_eval (
  input  wire esup_pkg::cfg_t    cfg,
  input  wire esup_pkg::state_t  st,
  input  wire esup_pkg::item_t   item,
  output esup_pkg::state_t       st_nxt,
  output esup_pkg::result_t      res
);

  logic        desired;
  logic [15:0] backoff_len;
  logic [31:0] link_elapsed;
  logic [31:0] fail_elapsed;
  logic        stop_w;
  logic        run_after_stop;
  logic        delay_met;
  logic        backoff_hold;
  logic        attempt_w;
  logic        is_tick;

  assign desired        = st.enabled && st.link_up && (st.current_gateway != 32'd0);
  assign backoff_len    = (cfg.retry_interval != 16'd0) ? cfg.retry_interval
                                                         : esup_pkg::RETRY_FALLBACK;
  assign link_elapsed   = item.time_now - st.link_up_time;
  assign fail_elapsed   = item.time_now - st.failure_time;
  assign stop_w         = st.running
                          && (!desired || (st.current_gateway != st.running_gateway));
  assign run_after_stop = st.running && !stop_w;
  assign delay_met      = link_elapsed >= {16'b0, cfg.link_wait};
  assign backoff_hold   = (st.failure_time != 32'd0) && (fail_elapsed < {16'b0, backoff_len});
  assign attempt_w      = !run_after_stop && desired && delay_met && !backoff_hold;
  assign is_tick        = item.command == esup_pkg::CMD_TICK;

  always_comb begin
    st_nxt = st;
    unique case (item.command)
      esup_pkg::CMD_SET_ENABLE: begin
        st_nxt.enabled = item.enable_value;
      end
      esup_pkg::CMD_LINK: begin
        if (item.link_connected && !st.link_up) begin
          st_nxt.link_up_time = item.time_now;
        end
        st_nxt.link_up         = item.link_connected;
        st_nxt.current_gateway = item.link_connected ? item.gateway_address : 32'd0;
      end
      esup_pkg::CMD_TICK: begin
        if (stop_w) begin
          st_nxt.running     = 1'b0;
          st_nxt.stops_total = st.stops_total + 32'd1;
        end
        if (attempt_w) begin
          if (item.start_ok) begin
            st_nxt.running         = 1'b1;
            st_nxt.running_gateway = st.current_gateway;
            st_nxt.starts_total    = st.starts_total + 32'd1;
            st_nxt.failure_time    = 32'd0;
          end else begin
            st_nxt.failures_total = st.failures_total + 32'd1;
            st_nxt.failure_time   = item.time_now;
          end
        end
      end
      esup_pkg::CMD_REPLY: begin
        st_nxt.replies_total = st.replies_total + 32'd1;
      end
      esup_pkg::CMD_TIMEOUT: begin
        st_nxt.timeouts_total = st.timeouts_total + 32'd1;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

  always_comb begin
    res.stop_issued     = is_tick && stop_w;
    res.start_attempted = is_tick && attempt_w;
    res.start_failed    = is_tick && attempt_w && !item.start_ok;
    if (st_nxt.running) begin
      res.target_gateway = st_nxt.running_gateway;
    end else if (is_tick && attempt_w) begin
      res.target_gateway = st.current_gateway;
    end else begin
      res.target_gateway = 32'd0;
    end
    res.session_active = st_nxt.running;
    res.started_count  = st_nxt.starts_total;
    res.stopped_count  = st_nxt.stops_total;
    res.failure_count  = st_nxt.failures_total;
    res.reply_count    = st_nxt.replies_total;
    res.timeout_count  = st_nxt.timeouts_total;
  end

endmodule

`default_nettype wire

// ===== rtl/core/echo_session_supervisor_top.sv =====
// Echo session supervisor.
// Event words enter on the in_ channel (in_valid / in_stall) and each one
// produces exactly one result word on the out_ channel (out_valid /
// out_stall), in order. Commands set the enable, report a link change,
// deliver a millisecond tick, or count an echo reply or timeout.
// A word is registered into the evaluation stage when it is accepted,
// evaluated there against the session state, and its result is registered
// when the result register is free, which raises out_valid. One word per
// cycle is sustained while out_stall is low; the single evaluation stage sets
// the rate and updates the state as each word moves into the result register.
// When out_stall is high with a result waiting, the evaluation stage keeps
// its word and in_stall goes high once that stage is occupied.
// Synchronous reset clears the state, all counters and both valid flags;
// the link wait resets to 0 and the retry interval to 1000 ms. The two
// registers sit at byte addresses 0 and 4 of the APB port; the user must write
// them only while idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module echo_session_supervisor_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,

  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [2:0]                      in_command,
  input  wire logic                            in_enable_value,
  input  wire logic                            in_link_connected,
  input  wire logic [31:0]                     in_gateway_address,
  input  wire logic [31:0]                     in_time_now,
  input  wire logic                            in_start_ok,

  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_stop_issued,
  output logic                                 out_start_attempted,
  output logic                                 out_start_failed,
  output logic [31:0]                          out_target_gateway,
  output logic                                 out_session_active,
  output logic [31:0]                          out_started_count,
  output logic [31:0]                          out_stopped_count,
  output logic [31:0]                          out_failure_count,
  output logic [31:0]                          out_reply_count,
  output logic [31:0]                          out_timeout_count,

  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [esup_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [esup_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [esup_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  esup_pkg::cfg_t    cfg;
  esup_pkg::item_t   stg_item_r;
  logic              stg_valid_r;
  logic              stg_valid_nxt;
  esup_pkg::state_t  state_r;
  esup_pkg::state_t  state_nxt;
  esup_pkg::result_t res_nxt;
  esup_pkg::result_t res_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_free;
  logic              stg_fire;
  logic              in_take;

  esup_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  esup_eval u_eval (
    .cfg    (cfg),
    .st     (state_r),
    .item   (stg_item_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  assign out_free      = !out_valid_r || !out_stall;
  assign stg_fire      = stg_valid_r && out_free;
  assign in_stall      = stg_valid_r && !out_free;
  assign in_take       = in_valid && !in_stall;
  assign stg_valid_nxt = in_take || (stg_valid_r && !out_free);
  assign out_valid_nxt = stg_fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (stg_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_item_r.command         <= in_command;
      stg_item_r.enable_value    <= in_enable_value;
      stg_item_r.link_connected  <= in_link_connected;
      stg_item_r.gateway_address <= in_gateway_address;
      stg_item_r.time_now        <= in_time_now;
      stg_item_r.start_ok        <= in_start_ok;
    end
    if (stg_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_stop_issued     = res_r.stop_issued;
  assign out_start_attempted = res_r.start_attempted;
  assign out_start_failed    = res_r.start_failed;
  assign out_target_gateway  = res_r.target_gateway;
  assign out_session_active  = res_r.session_active;
  assign out_started_count   = res_r.started_count;
  assign out_stopped_count   = res_r.stopped_count;
  assign out_failure_count   = res_r.failure_count;
  assign out_reply_count     = res_r.reply_count;
  assign out_timeout_count   = res_r.timeout_count;

  a_fail_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.start_failed |-> res_r.start_attempted && !res_r.session_active)
    else $error("failed start reported without attempt or with active session");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stg_valid_r)
    else $error("input stalled while the evaluation stage is empty");

  a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
    stg_fire |=> (state_r.starts_total - $past(state_r.starts_total))
      == {31'b0, $past(res_nxt.start_attempted && !res_nxt.start_failed)})
    else $error("start counter does not track successful starts");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_fire |=> $stable(state_r))
    else $error("session state changed without an evaluated word");

endmodule

`default_nettype wire
